>>> hdl/lbcg_pkg.sv
// Shared types, constants and mode tables for the LED blink code generator.
package lbcg_pkg;

  // Field widths
  localparam int REG_W  = 10;
  localparam int MODE_W = 3;
  localparam int CNT_W  = 3;
  localparam int IDX_W  = 2;

  // Defaults for the top-level parameters
  localparam int DEF_TICK_MS    = 10;
  localparam int DEF_TIMER_BITS = 10;

  // Number of defined modes; requests at or above this are dropped
  localparam logic [MODE_W-1:0] MODE_COUNT = MODE_W'(5);

  // Item opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_SLOW_FLASH = 2'd0;
  localparam logic [IDX_W-1:0] REG_FAST_FLASH = 2'd1;
  localparam logic [IDX_W-1:0] REG_PAUSE      = 2'd2;

  // Input item
  typedef struct packed {
    logic              op;
    logic [MODE_W-1:0] mode_request;
  } lbcg_in_t;

  // Result item
  typedef struct packed {
    logic              led_lit;
    logic [MODE_W-1:0] playing_mode;
  } lbcg_out_t;

  // Timing registers handed to the pattern engine
  typedef struct packed {
    logic [REG_W-1:0] slow_flash_ticks;
    logic [REG_W-1:0] fast_flash_ticks;
    logic [REG_W-1:0] pause_ticks;
  } lbcg_cfg_t;

  // Flashes per pattern for each mode
  function automatic logic [CNT_W-1:0] flash_target(input logic [MODE_W-1:0] mode);
    logic [CNT_W-1:0] n;
    case (mode)
      3'd0:    n = 3'd1;
      3'd1:    n = 3'd2;
      3'd2:    n = 3'd3;
      3'd3:    n = 3'd3;
      3'd4:    n = 3'd6;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  // Modes 0..2 repeat; one-shots and undefined codes do not
  function automatic logic mode_repeats(input logic [MODE_W-1:0] mode);
    return (mode < 3'd3);
  endfunction

endpackage

>>> hdl/lbcg_cfg_regs.sv
// Timing configuration registers with write port.
module lbcg_cfg_regs import lbcg_pkg::*; #(
  parameter int TICK_MS = DEF_TICK_MS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output lbcg_cfg_t        cfg
);

  localparam logic [REG_W-1:0] SLOW_RST  = REG_W'(250 / TICK_MS);
  localparam logic [REG_W-1:0] FAST_RST  = REG_W'(50 / TICK_MS);
  localparam logic [REG_W-1:0] PAUSE_RST = REG_W'(1000 / TICK_MS);

  // Register writes; unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_flash_ticks <= SLOW_RST;
      cfg.fast_flash_ticks <= FAST_RST;
      cfg.pause_ticks      <= PAUSE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SLOW_FLASH: cfg.slow_flash_ticks <= cfg_data;
        REG_FAST_FLASH: cfg.fast_flash_ticks <= cfg_data;
        REG_PAUSE:      cfg.pause_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/lbcg_pattern.sv
// Blink pattern state and single-step next-state logic.
module lbcg_pattern import lbcg_pkg::*; #(
  parameter int TIMER_BITS = DEF_TIMER_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  lbcg_in_t  item,
  input  lbcg_cfg_t cfg,
  output lbcg_out_t next_result
);

  logic                  flash_phase, flash_phase_next;
  logic [TIMER_BITS-1:0] tick_timer, tick_timer_next;
  logic [CNT_W-1:0]      flash_count, flash_count_next;
  logic [MODE_W-1:0]     active_mode, active_mode_next;
  logic [MODE_W-1:0]     home_mode, home_mode_next;
  logic [MODE_W-1:0]     requested_mode, requested_mode_next;
  logic                  change_pending, change_pending_next;
  logic                  return_pending, return_pending_next;
  logic                  lamp_state, lamp_state_next;

  logic [MODE_W-1:0]     pat_mode;
  logic [TIMER_BITS-1:0] timer_dec;
  logic [TIMER_BITS-1:0] flash_time;
  logic [TIMER_BITS-1:0] pause_time;

  // Undefined active mode takes the flash count of mode 0
  assign pat_mode   = (active_mode < MODE_COUNT) ? active_mode : '0;
  assign timer_dec  = (tick_timer != '0) ? tick_timer - 1'b1 : '0;
  assign flash_time = mode_repeats(active_mode) ? TIMER_BITS'(cfg.slow_flash_ticks)
                                                : TIMER_BITS'(cfg.fast_flash_ticks);
  assign pause_time = TIMER_BITS'(cfg.pause_ticks);

  // Next state for one item
  always_comb begin
    flash_phase_next    = flash_phase;
    tick_timer_next     = tick_timer;
    flash_count_next    = flash_count;
    active_mode_next    = active_mode;
    home_mode_next      = home_mode;
    requested_mode_next = requested_mode;
    change_pending_next = change_pending;
    return_pending_next = return_pending;
    lamp_state_next     = lamp_state;

    if (item.op == OP_TICK) begin
      tick_timer_next = timer_dec;
      if (timer_dec == '0) begin
        if (flash_phase == 1'b0) begin
          if (flash_count >= flash_target(pat_mode)) begin
            // Pattern boundary: long dark pause, pick up pending mode or return to home mode
            lamp_state_next  = 1'b0;
            flash_count_next = '0;
            tick_timer_next  = pause_time;
            if (change_pending) begin
              change_pending_next = 1'b0;
              active_mode_next    = requested_mode;
              return_pending_next = !mode_repeats(requested_mode);
            end else if (return_pending) begin
              return_pending_next = 1'b0;
              active_mode_next    = home_mode;
            end
          end else begin
            lamp_state_next  = 1'b1;
            tick_timer_next  = flash_time;
            flash_phase_next = 1'b1;
            flash_count_next = flash_count + 1'b1;
          end
        end else begin
          lamp_state_next  = 1'b0;
          tick_timer_next  = flash_time;
          flash_phase_next = 1'b0;
        end
      end
    end else if (item.mode_request < MODE_COUNT) begin
      // Mode request: mark pending, repeating modes become home
      change_pending_next = 1'b1;
      requested_mode_next = item.mode_request;
      if (mode_repeats(item.mode_request)) begin
        home_mode_next = item.mode_request;
      end
    end
  end

  assign next_result.led_lit      = lamp_state_next;
  assign next_result.playing_mode = active_mode_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_phase    <= 1'b0;
      tick_timer     <= '0;
      flash_count    <= '0;
      active_mode    <= '0;
      home_mode      <= '0;
      requested_mode <= '0;
      change_pending <= 1'b0;
      return_pending <= 1'b0;
      lamp_state     <= 1'b0;
    end else if (step) begin
      flash_phase    <= flash_phase_next;
      tick_timer     <= tick_timer_next;
      flash_count    <= flash_count_next;
      active_mode    <= active_mode_next;
      home_mode      <= home_mode_next;
      requested_mode <= requested_mode_next;
      change_pending <= change_pending_next;
      return_pending <= return_pending_next;
      lamp_state     <= lamp_state_next;
    end
  end

endmodule

>>> hdl/led_blink_code_generator_unit.sv
// An accepted transaction passes through the input register and then the result register (result_valid).
// Throughput: one transaction per cycle; the input register and the result register
// both advance together whenever the result register is empty or being taken.
// item_stall rises only while a result is held by result_stall and the input register is full.
// Reset (rst, synchronous): LED off, mode 0, timer cleared, timing registers to defaults.
module led_blink_code_generator_unit import lbcg_pkg::*; #(
  parameter int TICK_MS    = DEF_TICK_MS,
  parameter int TIMER_BITS = DEF_TIMER_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  lbcg_in_t         item,
  output logic             result_valid,
  input  logic             result_stall,
  output lbcg_out_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  lbcg_cfg_t cfg;
  lbcg_in_t  item_q;
  logic      item_q_valid;
  logic      advance;
  logic      step;
  lbcg_out_t next_result;

  assign cfg_ready  = 1'b1;
  assign advance    = !result_valid || !result_stall;
  assign step       = item_q_valid && advance;
  assign item_stall = item_q_valid && !advance;

  lbcg_cfg_regs #(.TICK_MS(TICK_MS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbcg_pattern #(.TIMER_BITS(TIMER_BITS)) u_pattern (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item_q),
    .cfg         (cfg),
    .next_result (next_result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      item_q <= item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= item_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= next_result;
    end
  end

  // A stepped transaction always lands in the result register
  assert property (@(posedge clk) disable iff (rst) step |=> result_valid)
    else $error("stepped transaction did not produce a result");

  // Stall only when the input register is full
  assert property (@(posedge clk) disable iff (rst) item_stall |-> item_q_valid)
    else $error("input stalled while input register empty");

  // Played mode is always a defined mode
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.playing_mode < MODE_COUNT))
    else $error("result carries undefined mode");

endmodule
